/* src/cspm_pkg.sv */
// ----------------------------------------------------------------------------
// cspm_pkg - shared types and constants of the pixel mapper
// Field widths, register indexes, crop sequencer states and pipeline payloads.
// ----------------------------------------------------------------------------
package cspm_pkg;

	localparam int DIM_W       = 14;               // image dimension
	localparam int COORD_W     = 13;               // pixel coordinate
	localparam int OFF_W       = 28;               // byte offset
	localparam int PB_W        = 3;                // bytes per pixel
	localparam int IDX_W       = 3;                // register index
	localparam int CFG_DATA_W  = 14;               // widest register
	localparam int QUO_W       = DIM_W;            // scaled coordinate quotient
	localparam int PROD_W      = COORD_W + DIM_W;  // coordinate times crop size
	localparam int REM_W       = DIM_W + 1;        // divider partial remainder
	localparam int DIV_BITS    = 2;                // quotient bits per divider stage
	localparam int DIV_STAGES  = QUO_W / DIV_BITS;
	localparam int CNT_W       = $clog2(QUO_W);
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 88;

	localparam logic [PB_W-1:0] PB_MIN = 3'd1;
	localparam logic [PB_W-1:0] PB_MAX = 3'd4;

	typedef enum logic [IDX_W-1:0] {
		REG_SRC_W,
		REG_SRC_H,
		REG_TGT_W,
		REG_TGT_H,
		REG_FILL,
		REG_FLIP,
		REG_PB
	} reg_idx_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_LOAD,
		CS_MUL_A,
		CS_MUL_B,
		CS_DIV,
		CS_FINISH
	} crop_state_t;

	// Effective configuration and precomputed crop window.
	typedef struct packed {
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] sh;
		logic [DIM_W-1:0] dw;
		logic [DIM_W-1:0] dh;
		logic             flip;
		logic [PB_W-1:0]  pb;
		logic [DIM_W-1:0] crop_w;
		logic [DIM_W-1:0] crop_h;
		logic [DIM_W-1:0] crop_x;
		logic [DIM_W-1:0] crop_y;
	} cfg_t;

	// One restoring-division lane: remainder and the dividend/quotient shifter.
	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] dq;
	} div_lane_t;

	typedef struct packed {
		div_lane_t          x;
		div_lane_t          y;
		logic [COORD_W-1:0] tx;
		logic [OFF_W-1:0]   tlin;
	} div_item_t;

endpackage

/* src/cspm_cfg.sv */
// ----------------------------------------------------------------------------
// cspm_cfg - register file and crop window sequencer
// Holds the registers, clamps them to legal values and recomputes the crop
// window after every write with one shared multiplier and a serial divider.
// ----------------------------------------------------------------------------
module cspm_cfg
	import cspm_pkg::*;
#(
	parameter int MAX_DIMENSION = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  logic [IDX_W-1:0]      wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg,
	output logic                  busy
);

	localparam logic [DIM_W:0] MAX_DIM = (DIM_W+1)'(MAX_DIMENSION);

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if ({1'b0, v} > MAX_DIM) begin
			r = MAX_DIM[DIM_W-1:0];
		end else begin
			r = v;
		end
		return r;
	endfunction

	logic [DIM_W-1:0] src_w_q, src_h_q, tgt_w_q, tgt_h_q;
	logic             fill_q, flip_q;
	logic [PB_W-1:0]  pb_q;

	logic [DIM_W-1:0] sw_q, sh_q, dw_q, dh_q;
	logic [PB_W-1:0]  pbe_q;

	crop_state_t       state_q, state_nxt;
	logic [2*DIM_W-1:0] prod_q;
	logic [2*DIM_W-1:0] mul_res;
	logic [DIM_W-1:0]   mul_a, mul_b;
	logic               gt_q;
	logic [REM_W-1:0]   rem_q;
	logic [QUO_W-1:0]   dq_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIM_W-1:0]   divisor_q;
	logic [DIM_W-1:0]   crop_w_q, crop_h_q, crop_x_q, crop_y_q;

	logic               wr_fire;
	logic [REM_W-1:0]   shift_rem;
	logic               q_bit;
	logic [2*DIM_W-1:0] dividend;

	assign wr_ready = 1'b1;
	assign wr_fire  = wr_valid && wr_ready;

	// Register writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= DIM_W'(1);
			src_h_q <= DIM_W'(1);
			tgt_w_q <= DIM_W'(1);
			tgt_h_q <= DIM_W'(1);
			fill_q  <= 1'b0;
			flip_q  <= 1'b0;
			pb_q    <= PB_MAX;
		end else if (wr_fire) begin
			case (wr_index)
				REG_SRC_W: src_w_q <= wr_data[DIM_W-1:0];
				REG_SRC_H: src_h_q <= wr_data[DIM_W-1:0];
				REG_TGT_W: tgt_w_q <= wr_data[DIM_W-1:0];
				REG_TGT_H: tgt_h_q <= wr_data[DIM_W-1:0];
				REG_FILL:  fill_q  <= wr_data[0];
				REG_FLIP:  flip_q  <= wr_data[0];
				REG_PB:    pb_q    <= wr_data[PB_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective values, registered from the raw registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q  <= DIM_W'(1);
			sh_q  <= DIM_W'(1);
			dw_q  <= DIM_W'(1);
			dh_q  <= DIM_W'(1);
			pbe_q <= PB_MAX;
		end else begin
			sw_q <= eff_dim(src_w_q);
			sh_q <= eff_dim(src_h_q);
			dw_q <= eff_dim(tgt_w_q);
			dh_q <= eff_dim(tgt_h_q);
			if (pb_q == '0) begin
				pbe_q <= PB_MIN;
			end else if (pb_q > PB_MAX) begin
				pbe_q <= PB_MAX;
			end else begin
				pbe_q <= pb_q;
			end
		end
	end

	// Shared multiplier: source width times destination height first, then destination width times source height.
	assign mul_a   = (state_q == CS_MUL_A) ? sw_q : dw_q;
	assign mul_b   = (state_q == CS_MUL_A) ? dh_q : sh_q;
	assign mul_res = (2*DIM_W)'(mul_a) * (2*DIM_W)'(mul_b);

	assign dividend  = (prod_q > mul_res) ? mul_res : prod_q;
	assign shift_rem = {rem_q[DIM_W-1:0], dq_q[QUO_W-1]};
	assign q_bit     = shift_rem >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		busy      = state_q != CS_IDLE;
		if (wr_fire) begin
			state_nxt = CS_LOAD;
		end else begin
			unique case (state_q)
				CS_IDLE:   state_nxt = CS_IDLE;
				CS_LOAD:   state_nxt = CS_MUL_A;
				CS_MUL_A:  state_nxt = CS_MUL_B;
				CS_MUL_B:  state_nxt = CS_DIV;
				CS_DIV:    state_nxt = (cnt_q == CNT_W'(QUO_W - 1)) ? CS_FINISH : CS_DIV;
				CS_FINISH: state_nxt = CS_IDLE;
				default:   state_nxt = CS_IDLE;
			endcase
		end
	end

	// Sequencer datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			CS_MUL_A: begin
				prod_q <= mul_res;
			end
			CS_MUL_B: begin
				gt_q      <= prod_q > mul_res;
				divisor_q <= (prod_q > mul_res) ? dh_q : dw_q;
				rem_q     <= REM_W'(dividend[2*DIM_W-1:QUO_W]);
				dq_q      <= dividend[QUO_W-1:0];
				cnt_q     <= '0;
			end
			CS_DIV: begin
				rem_q <= q_bit ? (shift_rem - {1'b0, divisor_q}) : shift_rem;
				dq_q  <= {dq_q[QUO_W-2:0], q_bit};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			default: begin
			end
		endcase
	end

	// Crop window; the reset value matches a one-pixel source mapped whole.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crop_w_q <= DIM_W'(1);
			crop_h_q <= DIM_W'(1);
			crop_x_q <= '0;
			crop_y_q <= '0;
		end else if (state_q == CS_FINISH) begin
			if (!fill_q) begin
				crop_w_q <= sw_q;
				crop_h_q <= sh_q;
				crop_x_q <= '0;
				crop_y_q <= '0;
			end else if (gt_q) begin
				crop_w_q <= dq_q;
				crop_h_q <= sh_q;
				crop_x_q <= (sw_q - dq_q) >> 1;
				crop_y_q <= '0;
			end else begin
				crop_w_q <= sw_q;
				crop_h_q <= dq_q;
				crop_x_q <= '0;
				crop_y_q <= (sh_q - dq_q) >> 1;
			end
		end
	end

	always_comb begin
		cfg.sw     = sw_q;
		cfg.sh     = sh_q;
		cfg.dw     = dw_q;
		cfg.dh     = dh_q;
		cfg.flip   = flip_q;
		cfg.pb     = pbe_q;
		cfg.crop_w = crop_w_q;
		cfg.crop_h = crop_h_q;
		cfg.crop_x = crop_x_q;
		cfg.crop_y = crop_y_q;
	end

	a_write_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		wr_fire |=> state_q == CS_LOAD)
		else $error("crop sequencer did not restart after a register write");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_FINISH |-> $past(state_q) == CS_DIV)
		else $error("crop sequencer finished without dividing");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_DIV |-> rem_q < {1'b0, divisor_q})
		else $error("crop divider remainder out of range");

endmodule

/* src/cspm_front.sv */
// ----------------------------------------------------------------------------
// cspm_front - coordinate clamp and scale products
// Saturates the destination coordinate, forms both scale products and the
// destination row base, and seeds the divider lanes.
// ----------------------------------------------------------------------------
module cspm_front
	import cspm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] target_col,
	input  logic [COORD_W-1:0] target_row,
	input  cfg_t               cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output div_item_t          out_item
);

	logic               valid_s1;
	div_item_t          item_s1;
	logic [COORD_W-1:0] tx_c, ty_c;
	logic [PROD_W-1:0]  prod_x, prod_y;
	div_item_t          item_nxt;

	assign tx_c = ({1'b0, target_col} >= cfg.dw) ? COORD_W'(cfg.dw - DIM_W'(1)) : target_col;
	assign ty_c = ({1'b0, target_row} >= cfg.dh) ? COORD_W'(cfg.dh - DIM_W'(1)) : target_row;

	assign prod_x = PROD_W'(tx_c) * PROD_W'(cfg.crop_w);
	assign prod_y = PROD_W'(ty_c) * PROD_W'(cfg.crop_h);

	always_comb begin
		item_nxt.x.rem = REM_W'(prod_x[PROD_W-1:QUO_W]);
		item_nxt.x.dq  = prod_x[QUO_W-1:0];
		item_nxt.y.rem = REM_W'(prod_y[PROD_W-1:QUO_W]);
		item_nxt.y.dq  = prod_y[QUO_W-1:0];
		item_nxt.tx    = tx_c;
		item_nxt.tlin  = OFF_W'(ty_c) * OFF_W'(cfg.dw);
	end

	assign in_ready  = !valid_s1 || out_ready;
	assign out_valid = valid_s1;
	assign out_item  = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item_nxt;
		end
	end

endmodule

/* src/cspm_div.sv */
// ----------------------------------------------------------------------------
// cspm_div - pipelined restoring divider for both scaled coordinates
// Divides the column product by the destination width and the row product by
// the destination height, a fixed number of quotient bits per stage.
// ----------------------------------------------------------------------------
module cspm_div
	import cspm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_item_t in_item,
	input  cfg_t      cfg,
	output logic      out_valid,
	input  logic      out_ready,
	output div_item_t out_item
);

	function automatic div_lane_t div_step(input div_lane_t l, input logic [DIM_W-1:0] d);
		div_lane_t        r;
		logic [REM_W-1:0] sh;
		logic             qb;
		sh    = {l.rem[DIM_W-1:0], l.dq[QUO_W-1]};
		qb    = sh >= {1'b0, d};
		r.rem = qb ? (sh - {1'b0, d}) : sh;
		r.dq  = {l.dq[QUO_W-2:0], qb};
		return r;
	endfunction

	div_item_t              item_s [DIV_STAGES];
	logic [DIV_STAGES-1:0]  valid_s;
	logic [DIV_STAGES-1:0]  rdy;
	div_item_t              src    [DIV_STAGES];
	logic [DIV_STAGES-1:0]  src_valid;
	div_item_t              nxt    [DIV_STAGES];

	always_comb begin
		rdy[DIV_STAGES-1] = !valid_s[DIV_STAGES-1] || out_ready;
		for (int i = DIV_STAGES - 2; i >= 0; i--) begin
			rdy[i] = !valid_s[i] || rdy[i+1];
		end
	end

	always_comb begin
		src[0]       = in_item;
		src_valid[0] = in_valid;
		for (int i = 1; i < DIV_STAGES; i++) begin
			src[i]       = item_s[i-1];
			src_valid[i] = valid_s[i-1];
		end
	end

	always_comb begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			nxt[i] = src[i];
			for (int b = 0; b < DIV_BITS; b++) begin
				nxt[i].x = div_step(nxt[i].x, cfg.dw);
				nxt[i].y = div_step(nxt[i].y, cfg.dh);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				if (rdy[i]) begin
					valid_s[i] <= src_valid[i];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < DIV_STAGES; i++) begin
			if (rdy[i] && src_valid[i]) begin
				item_s[i] <= nxt[i];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_item  = item_s[DIV_STAGES-1];

	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DIV_STAGES-1] |-> item_s[DIV_STAGES-1].x.rem < {1'b0, cfg.dw})
		else $error("column divider remainder not below destination width");

	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DIV_STAGES-1] |-> item_s[DIV_STAGES-1].y.rem < {1'b0, cfg.dh})
		else $error("row divider remainder not below destination height");

	a_quot_x: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[DIV_STAGES-1] && cfg.crop_w != '0 |->
			item_s[DIV_STAGES-1].x.dq < cfg.crop_w)
		else $error("scaled column outside the crop window");

endmodule

/* src/cspm_back.sv */
// ----------------------------------------------------------------------------
// cspm_back - crop offset, flip, bounds clamp and byte offsets
// Three stages: source coordinate, row-major index, byte offset scaling.
// ----------------------------------------------------------------------------
module cspm_back
	import cspm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  div_item_t          in_item,
	input  cfg_t               cfg,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COORD_W-1:0] source_col,
	output logic [COORD_W-1:0] source_row,
	output logic [OFF_W-1:0]   source_offset,
	output logic [OFF_W-1:0]   target_offset
);

	logic             valid_s1, valid_s2, valid_s3;
	logic             rdy1, rdy2, rdy3;
	logic [DIM_W-1:0] sx_s1, sy_s1, sx_s2, sy_s2, sx_s3, sy_s3;
	logic [OFF_W-1:0] tlin_s1, slin_s2, tlin_s2, soff_s3, toff_s3;

	logic [DIM_W:0]   sx_raw;
	logic [DIM_W+1:0] sy_raw;
	logic [DIM_W-1:0] sx_c, sy_c;

	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	// Place the scaled coordinate in the crop; flip counts rows from the crop bottom.
	assign sx_raw = {1'b0, cfg.crop_x} + {1'b0, in_item.x.dq};
	always_comb begin
		if (cfg.flip) begin
			sy_raw = {2'b0, cfg.crop_y} + {2'b0, cfg.crop_h} - (DIM_W+2)'(1)
			         - {2'b0, in_item.y.dq};
		end else begin
			sy_raw = {2'b0, cfg.crop_y} + {2'b0, in_item.y.dq};
		end
	end

	assign sx_c = (sx_raw >= {1'b0, cfg.sw}) ? (cfg.sw - DIM_W'(1)) : sx_raw[DIM_W-1:0];

	always_comb begin
		if (sy_raw[DIM_W+1]) begin
			sy_c = '0;
		end else if (sy_raw >= {2'b0, cfg.sh}) begin
			sy_c = cfg.sh - DIM_W'(1);
		end else begin
			sy_c = sy_raw[DIM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			sx_s1   <= sx_c;
			sy_s1   <= sy_c;
			tlin_s1 <= in_item.tlin + OFF_W'(in_item.tx);
		end
		if (rdy2 && valid_s1) begin
			sx_s2   <= sx_s1;
			sy_s2   <= sy_s1;
			slin_s2 <= OFF_W'(sy_s1) * OFF_W'(cfg.sw) + OFF_W'(sx_s1);
			tlin_s2 <= tlin_s1;
		end
		if (rdy3 && valid_s2) begin
			sx_s3   <= sx_s2;
			sy_s3   <= sy_s2;
			soff_s3 <= slin_s2 * OFF_W'(cfg.pb);
			toff_s3 <= tlin_s2 * OFF_W'(cfg.pb);
		end
	end

	assign out_valid     = valid_s3;
	assign source_col    = sx_s3[COORD_W-1:0];
	assign source_row    = sy_s3[COORD_W-1:0];
	assign source_offset = soff_s3;
	assign target_offset = toff_s3;

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> sx_s1 < cfg.sw)
		else $error("source column outside the source image");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> sy_s1 < cfg.sh)
		else $error("source row outside the source image");

	a_no_flip_row: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !cfg.flip && cfg.crop_h != '0 |-> sy_s1 >= cfg.crop_y)
		else $error("unflipped source row above the crop window");

endmodule

/* src/crop_scale_flip_pixel_mapper_unit.sv */
// ----------------------------------------------------------------------------
// crop_scale_flip_pixel_mapper_unit - nearest-neighbor scaling address generator
// Maps a destination pixel to the source pixel it copies and gives both
// row-major byte offsets, with optional aspect-fill crop and vertical flip.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one request per destination pixel (target_col, target_row).
//   Master stream: one result per request, in order (source_col, source_row,
//   source_offset, target_offset).
//   Configuration channel: cfg_index selects a register (0 source width,
//   1 source height, 2 target width, 3 target height, 4 fill mode, 5 row flip,
//   6 bytes per pixel); cfg_data carries the value. Write only while the
//   stream is drained.
//   Throughput: one request per clock while the master side is ready and no
//   crop recompute runs. Pipeline: 1 clamp/multiply stage, 7 divider stages of
//   two quotient bits each, 3 address stages.
//   After every register write, the crop sequencer runs (one shared multiplier,
//   then a bit-serial divider, 14 steps); s_axis_tready stays low meanwhile.
//   Reset values give a one-pixel source and destination, whole-source
//   mapping, no flip, four bytes per pixel; the crop reset matches so no
//   sequencer pass follows reset.
//   Backpressure: each stage holds its request while the next is full; a
//   stalled master side fills the bubbles and then stops the slave side.
//   Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module crop_scale_flip_pixel_mapper_unit
	import cspm_pkg::*;
#(
	parameter int MAX_DIMENSION = 8192
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// [12:0] target_col, [25:13] target_row, [31:26] zero
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [12:0] source_col, [25:13] source_row, [53:26] source_offset,
	// [81:54] target_offset, [87:82] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t               cfg;
	logic               busy;
	logic               front_ready;
	logic               front_valid, div_in_ready;
	div_item_t          front_item;
	logic               div_valid, back_in_ready;
	div_item_t          div_item;
	logic [COORD_W-1:0] source_col, source_row;
	logic [OFF_W-1:0]   source_offset, target_offset;

	// Registers and crop window.
	cspm_cfg #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_ready (cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg),
		.busy     (busy)
	);

	// Hold off requests while the crop window is recomputed.
	assign s_axis_tready = front_ready && !busy;

	cspm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid && !busy),
		.in_ready   (front_ready),
		.target_col (s_axis_tdata[COORD_W-1:0]),
		.target_row (s_axis_tdata[2*COORD_W-1:COORD_W]),
		.cfg        (cfg),
		.out_valid  (front_valid),
		.out_ready  (div_in_ready),
		.out_item   (front_item)
	);

	cspm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (div_in_ready),
		.in_item   (front_item),
		.cfg       (cfg),
		.out_valid (div_valid),
		.out_ready (back_in_ready),
		.out_item  (div_item)
	);

	cspm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (div_valid),
		.in_ready      (back_in_ready),
		.in_item       (div_item),
		.cfg           (cfg),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.source_col    (source_col),
		.source_row    (source_row),
		.source_offset (source_offset),
		.target_offset (target_offset)
	);

	// Pack the result, first field lowest, zero fill to whole bytes.
	assign m_axis_tdata = {
		(OUT_TDATA_W - 2*COORD_W - 2*OFF_W)'(0),
		target_offset,
		source_offset,
		source_row,
		source_col
	};

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> busy)
		else $error("register write did not start a crop recompute");

	a_crop_fits: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> cfg.crop_w <= cfg.sw && cfg.crop_h <= cfg.sh)
		else $error("crop window larger than the source");

	a_whole_source: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !u_cfg.fill_q |-> cfg.crop_w == cfg.sw && cfg.crop_h == cfg.sh
			&& cfg.crop_x == '0 && cfg.crop_y == '0)
		else $error("crop window not the whole source with fill mode off");

endmodule

/* test/cspm_map_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cspm_map_checker - result checker of the pixel mapper
// Follows the register writes and destination pixel requests of the mapper,
// computes the source pick each request calls for and compares every result
// field with the oldest pick still waiting.
// ----------------------------------------------------------------------------
module cspm_map_checker
	import cspm_pkg::*;
#(
	parameter int MAX_DIMENSION = 8192
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [IDX_W-1:0]       cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     fail_count,
	output int                     pending_results
);

	localparam int PAD_W = OUT_TDATA_W - 2 * COORD_W - 2 * OFF_W;

	// Result layout, lowest field last.
	typedef struct packed {
		logic [PAD_W-1:0]   pad;
		logic [OFF_W-1:0]   dst_off;
		logic [OFF_W-1:0]   src_off;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} src_pick_t;

	logic [DIM_W-1:0] src_w, src_h, dst_w, dst_h;
	logic             fill_on, flip_on;
	logic [PB_W-1:0]  bytes_per_px;

	src_pick_t expected_reads[$];
	src_pick_t want, got;
	int        errors = 0;
	int        results_seen = 0;

	assign fail_count = errors;

	function automatic longint span(input logic [DIM_W-1:0] raw);
		if (raw == 0)
			return 1;
		if (raw > MAX_DIMENSION)
			return MAX_DIMENSION;
		return raw;
	endfunction

	function automatic longint clamp_to(input longint v, input longint limit);
		if (v >= limit)
			v = limit - 1;
		if (v < 0)
			v = 0;
		return v;
	endfunction

	function automatic src_pick_t map_pixel(input logic [COORD_W-1:0] col,
			input logic [COORD_W-1:0] row);
		longint sw, sh, dw, dh, pb, tx, ty;
		longint crop_w, crop_h, crop_x, crop_y, sx, sy, step_y;
		src_pick_t r;
		sw = span(src_w);
		sh = span(src_h);
		dw = span(dst_w);
		dh = span(dst_h);
		pb = bytes_per_px;
		if (pb < PB_MIN)
			pb = PB_MIN;
		if (pb > PB_MAX)
			pb = PB_MAX;
		tx = col;
		ty = row;
		if (tx > dw - 1)
			tx = dw - 1;
		if (ty > dh - 1)
			ty = dh - 1;
		crop_w = sw;
		crop_h = sh;
		crop_x = 0;
		crop_y = 0;
		// Centered crop with the destination aspect; the wider side gets cut.
		if (fill_on) begin
			if (sw * dh > dw * sh) begin
				crop_w = (sh * dw) / dh;
				crop_x = (sw - crop_w) / 2;
			end else begin
				crop_h = (sw * dh) / dw;
				crop_y = (sh - crop_h) / 2;
			end
		end
		sx = crop_x + (tx * crop_w) / dw;
		step_y = (ty * crop_h) / dh;
		sy = flip_on ? crop_y + (crop_h - 1 - step_y) : crop_y + step_y;
		sx = clamp_to(sx, sw);
		sy = clamp_to(sy, sh);
		r.pad     = '0;
		r.col     = sx[COORD_W-1:0];
		r.row     = sy[COORD_W-1:0];
		r.src_off = OFF_W'((sy * sw + sx) * pb);
		r.dst_off = OFF_W'((ty * dw + tx) * pb);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [OFF_W-1:0] seen,
			input logic [OFF_W-1:0] wanted);
		$display("%0t: result %0d %s: got %0d, expected %0d", $realtime, results_seen,
			what, seen, wanted);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w = 1;
			src_h = 1;
			dst_w = 1;
			dst_h = 1;
			fill_on = 1'b0;
			flip_on = 1'b0;
			bytes_per_px = PB_MAX;
			expected_reads.delete();
			pending_results <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_SRC_W: src_w = cfg_data[DIM_W-1:0];
				REG_SRC_H: src_h = cfg_data[DIM_W-1:0];
				REG_TGT_W: dst_w = cfg_data[DIM_W-1:0];
				REG_TGT_H: dst_h = cfg_data[DIM_W-1:0];
				REG_FILL:  fill_on = cfg_data[0];
				REG_FLIP:  flip_on = cfg_data[0];
				REG_PB:    bytes_per_px = cfg_data[PB_W-1:0];
				default: ;
				endcase
			end
			// Match results before taking new requests, so a zero-delay result is caught.
			if (m_axis_tvalid && m_axis_tready) begin
				got = src_pick_t'(m_axis_tdata);
				results_seen++;
				if (expected_reads.size() == 0) begin
					report_mismatch("result with no request waiting", got.src_off, '0);
				end else begin
					want = expected_reads.pop_front();
					if (got.col !== want.col)
						report_mismatch("source_col", OFF_W'(got.col), OFF_W'(want.col));
					if (got.row !== want.row)
						report_mismatch("source_row", OFF_W'(got.row), OFF_W'(want.row));
					if (got.src_off !== want.src_off)
						report_mismatch("source_offset", got.src_off, want.src_off);
					if (got.dst_off !== want.dst_off)
						report_mismatch("target_offset", got.dst_off, want.dst_off);
					if (got.pad !== want.pad)
						report_mismatch("padding bits", OFF_W'(got.pad), OFF_W'(want.pad));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				expected_reads.push_back(map_pixel(s_axis_tdata[COORD_W-1:0],
					s_axis_tdata[2*COORD_W-1:COORD_W]));
			pending_results <= expected_reads.size();
		end
	end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of crop_scale_flip_pixel_mapper_unit
// Programs a series of image geometries, from the reset one through the size
// extremes to random ones, streams destination pixels through the mapper with
// bursty requests and a stalling result side, and lets the checker compare
// every source pick and byte offset.
// ----------------------------------------------------------------------------
module tb;
	import cspm_pkg::*;

	localparam int MAX_DIM         = 8192;
	localparam int RANDOM_PHASES   = 14;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int HOLD_CYCLES     = 400;   // long result-side hold-off
	localparam int SETTLE_CYCLES   = 30;    // extra wait after the final drain
	localparam int WATCHDOG_LIMIT  = 5000;  // cycles without any handshake on any channel

	// Index with no register behind it; the block must ignore the write.
	localparam logic [IDX_W-1:0] REG_UNUSED = '1;

	// Raw register values of one image geometry, written as given.
	typedef struct {
		logic [CFG_DATA_W-1:0] sw;
		logic [CFG_DATA_W-1:0] sh;
		logic [CFG_DATA_W-1:0] dw;
		logic [CFG_DATA_W-1:0] dh;
		logic [CFG_DATA_W-1:0] fill;
		logic [CFG_DATA_W-1:0] flip;
		logic [CFG_DATA_W-1:0] pb;
	} setting_t;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_SPARSE,
		SINK_PERIODIC
	} sink_mode_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [IDX_W-1:0]       cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int       fail_count;
	int       pending_results;
	int       quiet_cycles = 0;
	int       burst_left;
	bit       offering;
	bit       sink_hold_req = 1'b0;
	setting_t cur;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	crop_scale_flip_pixel_mapper_unit #(
		.MAX_DIMENSION(MAX_DIM)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cspm_map_checker #(
		.MAX_DIMENSION(MAX_DIM)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending_results(pending_results)
	);

	// Drop the request valid if it is up; at most once per time step.
	task automatic stop_offer();
		if (offering) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Offer one destination pixel and hold it until the mapper takes it.
	// Requests come in bursts; a random gap follows each burst.
	task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row);
		if (burst_left == 0) begin
			stop_offer();
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - 2 * COORD_W){1'b0}}, row, col};
		offering = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Stop requesting and wait until every expected result is back.
	task automatic wait_drained();
		stop_offer();
		do @(posedge clk); while (pending_results != 0);
	endtask

	// Leave valid up; the caller lowers it after the last write of a batch.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic apply_setting(input setting_t s, input bit poke_unused);
		if (poke_unused)
			write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
		write_reg(REG_SRC_W, s.sw);
		write_reg(REG_SRC_H, s.sh);
		write_reg(REG_TGT_W, s.dw);
		write_reg(REG_TGT_H, s.dh);
		write_reg(REG_FILL, s.fill);
		write_reg(REG_FLIP, s.flip);
		write_reg(REG_PB, s.pb);
		cfg_valid <= 1'b0;
		cur = s;
	endtask

	// Mostly small images, some full range, and now and then a size the block
	// has to saturate (zero or above the maximum).
	function automatic logic [CFG_DATA_W-1:0] pick_dim();
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return CFG_DATA_W'($urandom_range(1, 32));
		4, 5:       return CFG_DATA_W'($urandom_range(1, 1024));
		6, 7:       return CFG_DATA_W'($urandom_range(1, MAX_DIM));
		8:          return ($urandom_range(0, 1) == 0) ? CFG_DATA_W'(1) : CFG_DATA_W'(MAX_DIM);
		default:    return ($urandom_range(0, 3) == 0) ? '0
				: CFG_DATA_W'($urandom_range(MAX_DIM + 1, (1 << CFG_DATA_W) - 1));
		endcase
	endfunction

	// One-bit register: mostly 0 or 1, sometimes junk in the upper bits.
	function automatic logic [CFG_DATA_W-1:0] pick_flag();
		if ($urandom_range(0, 7) == 0)
			return CFG_DATA_W'($urandom);
		return CFG_DATA_W'($urandom_range(0, 1));
	endfunction

	function automatic setting_t random_setting();
		setting_t s;
		s.sw   = pick_dim();
		s.sh   = pick_dim();
		s.dw   = pick_dim();
		s.dh   = pick_dim();
		s.fill = pick_flag();
		s.flip = pick_flag();
		case ($urandom_range(0, 7))
		0:       s.pb = CFG_DATA_W'($urandom);
		1, 2:    s.pb = CFG_DATA_W'($urandom_range(0, 7));
		default: s.pb = CFG_DATA_W'($urandom_range(PB_MIN, PB_MAX));
		endcase
		return s;
	endfunction

	// Coordinate against a raw destination size: mostly inside, with the
	// edges and the full field range mixed in.
	function automatic logic [COORD_W-1:0] pick_coord(input logic [CFG_DATA_W-1:0] raw_dim);
		int lim;
		lim = (raw_dim == 0) ? 1 : (raw_dim > MAX_DIM) ? MAX_DIM : raw_dim;
		case ($urandom_range(0, 9))
		0:       return COORD_W'($urandom);
		1:       return COORD_W'(lim - 1);
		2:       return '0;
		default: return COORD_W'($urandom_range(0, lim - 1));
		endcase
	endfunction

	initial begin : stimulus
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_SRC_W;
		cfg_data      <= '0;
		cur        = setting_t'{1, 1, 1, 1, 0, 0, 4};
		burst_left = 0;
		offering   = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset geometry: one-pixel source and destination; out-of-range
		// coordinates saturate to the single pixel.
		send_pixel(0, 0);
		send_pixel(8191, 8191);
		send_pixel(1, 0);

		// Largest images: offsets reach their top values.
		wait_drained();
		apply_setting(setting_t'{8192, 8192, 8192, 8192, 0, 0, 4}, 1'b0);
		send_pixel(0, 0);
		send_pixel(8191, 8191);
		send_pixel(8191, 0);
		send_pixel(0, 8191);

		// Sizes of zero and above the maximum, bytes per pixel zero.
		wait_drained();
		apply_setting(setting_t'{0, 16383, 16383, 0, 1, 1, 0}, 1'b0);
		send_pixel(5, 5);
		send_pixel(8191, 8191);

		// Wide source filled into a tall target: the crop width floors to zero.
		wait_drained();
		apply_setting(setting_t'{8192, 1, 1, 8192, 1, 0, 7}, 1'b0);
		send_pixel(0, 0);
		send_pixel(0, 8191);
		send_pixel(8191, 100);

		// Tall source into a wide target, flipped: empty crop height.
		wait_drained();
		apply_setting(setting_t'{1, 8192, 8192, 1, 1, 1, 5}, 1'b0);
		send_pixel(0, 0);
		send_pixel(8191, 0);

		// Flag writes with upper bits set, plus a write to the unused index.
		wait_drained();
		apply_setting(setting_t'{640, 480, 1920, 1080, 2, 3, 3}, 1'b1);
		send_pixel(0, 0);
		send_pixel(1919, 1079);
		send_pixel(1920, 1080);

		// Ordinary 4:3 to 16:9 fill with flip.
		wait_drained();
		apply_setting(setting_t'{640, 480, 1920, 1080, 1, 1, 2}, 1'b0);
		send_pixel(0, 0);
		send_pixel(1919, 1079);
		send_pixel(960, 540);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drained();
			apply_setting(random_setting(), p % 4 == 0);
			// Hold results off for a long stretch so the pipeline backs up.
			if (p == 1)
				sink_hold_req = 1'b1;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Pause mid-stream until the mapper is empty.
				if (p == 4 && n == ITEMS_PER_PHASE / 2)
					wait_drained();
				send_pixel(pick_coord(cur.dw), pick_coord(cur.dh));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("crop_scale_flip_pixel_mapper_unit test passed");
		else
			$display("crop_scale_flip_pixel_mapper_unit test failed");
		$finish;
	end

	// Result side: switch between stall patterns of random length, and honor
	// one long hold-off when asked.
	initial begin : result_sink
		sink_mode_t mode;
		int         mode_left;
		int         beat;
		mode          = SINK_OPEN;
		mode_left     = 0;
		beat          = 0;
		m_axis_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			beat++;
			if (sink_hold_req) begin
				sink_hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
			end else begin
				if (mode_left == 0) begin
					mode      = sink_mode_t'($urandom_range(SINK_OPEN, SINK_PERIODIC));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
				SINK_OPEN:   m_axis_tready <= 1'b1;
				SINK_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
				SINK_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default:     m_axis_tready <= (beat % 3 == 0);
				endcase
			end
		end
	end

	// Watchdog: end the run when no channel moves a request for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("crop_scale_flip_pixel_mapper_unit test failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
